@@ sv/stepdet_pkg.sv @@
// ----------------------------------------------------------------------------
// Step detector package
// Shared constants, result type and the divide-by-ten helper.
// ----------------------------------------------------------------------------
package stepdet_pkg;

    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned RUN_CNT_W  = 4;
    localparam int unsigned SUM_W      = 12;
    localparam int unsigned THRESH_W   = 9;
    localparam int unsigned TOTAL_W    = 32;

    // Number of rising runs used for calibration.
    localparam logic [RUN_CNT_W-1:0] CAL_RUNS = 4'd11;

    // Division by ten as multiplication by ceil(2^15 / 10), exact for 12-bit values.
    localparam int unsigned              RECIP_SHIFT = 15;
    localparam logic [SUM_W-1:0]         RECIP_TEN   = 12'd3277;

    typedef struct packed {
        logic [TOTAL_W-1:0]  steps_so_far;
        logic                step_now;
        logic                in_calibration;
        logic [THRESH_W-1:0] threshold_now;
    } stepdet_result_t;

    function automatic logic [THRESH_W-1:0] div_by_ten(input logic [SUM_W-1:0] x);
        logic [2*SUM_W-1:0] prod;
        prod = x * RECIP_TEN;
        return prod[RECIP_SHIFT +: THRESH_W];
    endfunction

endpackage

@@ sv/stepdet_core.sv @@
// ----------------------------------------------------------------------------
// Step detector core
// Holds the sample history and calibration state and computes one result
// per processed transaction.
// ----------------------------------------------------------------------------
module stepdet_core
    import stepdet_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                restart,
    output stepdet_result_t     result
);

    logic [SAMPLE_W-1:0]  hist0_reg, hist1_reg;
    logic [SAMPLE_W-1:0]  hist0_next, hist1_next;
    logic [RUN_CNT_W-1:0] run_count_reg, run_count_next;
    logic [SUM_W-1:0]     delta_sum_reg, delta_sum_next;
    logic [THRESH_W-1:0]  threshold_reg, threshold_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;

    logic                 rising;
    logic [SAMPLE_W-1:0]  rise;
    logic                 stepped;
    logic [THRESH_W-1:0]  quot;

    always_comb begin
        // The oldest sample is hist1_reg, the middle one hist0_reg, newest is sample.
        rising  = (hist1_reg < hist0_reg) && (hist0_reg < sample);
        rise    = sample - hist1_reg;
        quot    = div_by_ten(delta_sum_reg);
        stepped = 1'b0;

        hist0_next     = sample;
        hist1_next     = hist0_reg;
        run_count_next = run_count_reg;
        delta_sum_next = delta_sum_reg;
        threshold_next = threshold_reg;
        total_next     = total_reg;

        if (restart) begin
            hist0_next     = '0;
            hist1_next     = '0;
            run_count_next = '0;
            delta_sum_next = '0;
            threshold_next = '0;
            total_next     = '0;
        end else if (rising && (run_count_reg < CAL_RUNS)) begin
            run_count_next = run_count_reg + 1'b1;
            delta_sum_next = delta_sum_reg + {{(SUM_W-SAMPLE_W){1'b0}}, rise};
        end else begin
            threshold_next = quot;
            if (rising && ({1'b0, rise} >= quot)) begin
                total_next = total_reg + 1'b1;
                stepped    = 1'b1;
            end
        end

        result.steps_so_far   = total_next;
        result.step_now       = stepped;
        result.in_calibration = (run_count_next < CAL_RUNS);
        result.threshold_now  = threshold_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist0_reg     <= '0;
            hist1_reg     <= '0;
            run_count_reg <= '0;
            delta_sum_reg <= '0;
            threshold_reg <= '0;
            total_reg     <= '0;
        end else if (fire) begin
            hist0_reg     <= hist0_next;
            hist1_reg     <= hist1_next;
            run_count_reg <= run_count_next;
            delta_sum_reg <= delta_sum_next;
            threshold_reg <= threshold_next;
            total_reg     <= total_next;
        end
    end

endmodule

@@ sv/step_detector_self_calibrating.sv @@
// ----------------------------------------------------------------------------
// Self-calibrating step detector
// Counts steps from a stream of accelerometer samples after learning a rise
// threshold from the first eleven rising runs.
// ----------------------------------------------------------------------------
// The input register takes a transaction when it is accepted; the result
// register takes its result when the core processes it, which raises m_valid.
// The result handshake is held back while the result side stalls.
// Throughput: one transaction per cycle while the result side does not stall,
// set by the single compute step between the input and result registers.
// Reset: aresetn, synchronous and active low, clears both pipeline stages and
// all detector state; the restart field clears the detector state in-band.
// ----------------------------------------------------------------------------
module step_detector_self_calibrating
    import stepdet_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sample,
    input  logic                s_restart,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [TOTAL_W-1:0]  m_steps_so_far,
    output logic                m_step_now,
    output logic                m_in_calibration,
    output logic [THRESH_W-1:0] m_threshold_now
);

    // Input register: holds one accepted transaction until the core processes it.
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                in_restart_reg;

    // Result register: holds one finished result until the consumer takes it.
    logic                out_valid_reg;
    stepdet_result_t     out_result_reg;

    stepdet_result_t     core_result;
    logic                fire;

    // The core processes the buffered transaction whenever the result register
    // is free or is being emptied in this same cycle. The detector state is
    // updated at that moment, so each sample sees the history of the previous
    // one without any bubble.
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);

    // A new sample may enter whenever the input register is empty or is
    // handing its transaction to the core in this cycle.
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Payload needs no reset; it is qualified by the valid bit.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg  <= s_sample;
            in_restart_reg <= s_restart;
        end
    end

    stepdet_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .sample  (in_sample_reg),
        .restart (in_restart_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_result_reg <= core_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_steps_so_far   = out_result_reg.steps_so_far;
    assign m_step_now       = out_result_reg.step_now;
    assign m_in_calibration = out_result_reg.in_calibration;
    assign m_threshold_now  = out_result_reg.threshold_now;

endmodule

@@ tb/sv/tb_step_detector_self_calibrating.sv @@
// ----------------------------------------------------------------------------
// Testbench for the self-calibrating step detector
// Sends sample transactions through the valid/ready input channel and checks
// every result transaction against a cycle-free model of the detector. The
// model learns its threshold from the first eleven rising runs and counts
// later steps. Random ramps, noise, restarts and worst-case calibration
// patterns run under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_step_detector_self_calibrating;
    import stepdet_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_PCT     = 37;
    localparam int RANDOM_ITEMS = 1900;
    localparam int CAL_DIVISOR  = 10;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 150000;
    // Transactions within this window run with no idling on either side.
    localparam int CALM_FROM    = 700;
    localparam int CALM_TO      = 1000;

    // One pending input transaction. When drain_first is set, the driver holds
    // it back until every result that is still owed has been checked.
    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                restart;
        logic                drain_first;
    } sample_item_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_sample  = '0;
    logic                s_restart = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [TOTAL_W-1:0]  m_steps_so_far;
    logic                m_step_now;
    logic                m_in_calibration;
    logic [THRESH_W-1:0] m_threshold_now;

    sample_item_t    sample_backlog[$];
    stepdet_result_t expected_results[$];

    int  mismatch_count  = 0;
    int  accepted_count  = 0;
    int  checked_count   = 0;
    int  cycle_count     = 0;
    int  queued_count    = 0;
    bit  drain_due       = 1'b0;

    // Detector state as the model sees it. hist[0] is the newest sample.
    logic [SAMPLE_W-1:0]  hist[3];
    logic [RUN_CNT_W-1:0] runs_seen;
    logic [SUM_W-1:0]     rise_sum;
    logic [THRESH_W-1:0]  rise_limit;
    logic [TOTAL_W-1:0]   step_count;

    step_detector_self_calibrating dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_steps_so_far   (m_steps_so_far),
        .m_step_now       (m_step_now),
        .m_in_calibration (m_in_calibration),
        .m_threshold_now  (m_threshold_now)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Step prediction
    // ------------------------------------------------------------------------

    // Clears the detector state, both at reset and on a restart transaction.
    function automatic void clear_detector();
        hist[0]    = '0;
        hist[1]    = '0;
        hist[2]    = '0;
        runs_seen  = '0;
        rise_sum   = '0;
        rise_limit = '0;
        step_count = '0;
    endfunction

    // Advances the detector by one accepted sample and returns the result that
    // the block must produce for it.
    function automatic stepdet_result_t detect_step(input logic [SAMPLE_W-1:0] smp,
                                                    input logic restart);
        stepdet_result_t   res;
        logic              rising;
        logic [SAMPLE_W:0] rise;
        logic              stepped;

        stepped = 1'b0;
        if (restart) begin
            clear_detector();
        end else begin
            hist[2] = hist[1];
            hist[1] = hist[0];
            hist[0] = smp;
            rising  = (hist[2] < hist[1]) && (hist[1] < hist[0]);
            rise    = {1'b0, hist[0]} - {1'b0, hist[2]};
            // A rising run is absorbed by calibration until eleven have been
            // gathered. Any other sample refreshes the threshold first, so the
            // threshold can move while calibration is still under way.
            if (rising && runs_seen < CAL_RUNS) begin
                runs_seen = runs_seen + 1'b1;
                rise_sum  = rise_sum + rise;
            end else begin
                rise_limit = THRESH_W'(rise_sum / CAL_DIVISOR);
                if (rising && rise >= rise_limit) begin
                    step_count = step_count + 1'b1;
                    stepped    = 1'b1;
                end
            end
        end
        res.steps_so_far   = step_count;
        res.step_now       = stepped;
        res.in_calibration = (runs_seen < CAL_RUNS);
        res.threshold_now  = rise_limit;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------

    task automatic push_sample(input int smp, input bit restart);
        sample_item_t it;
        it.sample      = smp[SAMPLE_W-1:0];
        it.restart     = restart;
        it.drain_first = drain_due;
        drain_due      = 1'b0;
        sample_backlog.push_back(it);
        queued_count++;
    endtask

    // A strictly increasing ramp. Each interior sample completes a rising run
    // whose rise is the sum of two increments, so the size of the increments
    // decides whether the run clears the learned threshold.
    task automatic add_ramp();
        int len;
        int inc_max;
        int val;
        int inc;

        len = $urandom_range(3, 8);
        case ($urandom_range(0, 4))
            0: inc_max = 1;
            1: inc_max = 4;
            2: inc_max = 15;
            3: inc_max = 50;
            default: inc_max = 127;
        endcase
        val = $urandom_range(0, 200);
        push_sample(val, 1'b0);
        for (int k = 1; k < len; k++) begin
            inc = $urandom_range(1, inc_max);
            if (val + inc > 255) begin
                break;
            end
            val += inc;
            push_sample(val, 1'b0);
        end
    endtask

    // The pattern 0, 128, 255 gives the largest possible rise on every third
    // sample. Eleven of them right after a restart drive the threshold to its
    // maximum.
    task automatic add_full_swings(input int reps);
        for (int k = 0; k < reps; k++) begin
            push_sample(0, 1'b0);
            push_sample(128, 1'b0);
            push_sample(255, 1'b0);
        end
    endtask

    // Flat or falling samples: none after the first completes a rising run, so
    // each of those refreshes the threshold.
    task automatic add_flat_or_falling();
        int val;
        int n;

        val = $urandom_range(0, 255);
        n   = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) begin
            push_sample(val, 1'b0);
            if ($urandom_range(0, 1) == 1) begin
                val = $urandom_range(0, val);
            end
        end
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            push_sample($urandom_range(0, 255), 1'b0);
        end
    endtask

    task automatic build_stimulus();
        int kind;
        bit drained_mid;
        bit drained_late;

        drained_mid  = 1'b0;
        drained_late = 1'b0;

        // Directed part. A restart with an ignored sample, then a ramp in steps
        // of ten from the zero history: the first rising run appears on the
        // third sample and the eleventh ends calibration with a sum of 220.
        push_sample(255, 1'b1);
        for (int v = 0; v <= 120; v += 10) begin
            push_sample(v, 1'b0);
        end
        // First run after calibration: rise 20 falls just under threshold 22.
        // The next two rise by 35 and 47 and count.
        push_sample(130, 1'b0);
        push_sample(155, 1'b0);
        push_sample(177, 1'b0);
        // Drop to zero, then a run with a rise of 211, a run whose rise equals the
        // threshold exactly and a run that ends on the largest sample value.
        push_sample(0, 1'b0);
        push_sample(200, 1'b0);
        push_sample(211, 1'b0);
        push_sample(222, 1'b0);
        push_sample(255, 1'b0);
        push_sample(0, 1'b1);

        // Random part: mostly ramps with random content, the rest noise, flat
        // stretches, full swings and restarts.
        drain_due = 1'b1;
        while (queued_count < RANDOM_ITEMS + 22) begin
            if (!drained_mid && queued_count >= 600) begin
                drain_due   = 1'b1;
                drained_mid = 1'b1;
            end
            if (!drained_late && queued_count >= 1500) begin
                drain_due    = 1'b1;
                drained_late = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 4) begin
                push_sample($urandom_range(0, 255), 1'b1);
                if ($urandom_range(0, 1) == 1) begin
                    add_full_swings(11 + $urandom_range(0, 2));
                end
            end else if (kind < 14) begin
                add_noise();
            end else if (kind < 24) begin
                add_flat_or_falling();
            end else if (kind < 30) begin
                add_full_swings($urandom_range(1, 3));
            end else begin
                add_ramp();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver: presents queued transactions and predicts each one as it
    // is accepted.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive_samples
        sample_item_t nxt;
        bit           calm;
        bit           offer;

        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(detect_step(s_sample, s_restart));
                accepted_count++;
            end
            // A new transaction may be presented only when the current one,
            // if any, has just been taken.
            if (!s_valid || s_ready) begin
                calm  = (accepted_count >= CALM_FROM) && (accepted_count < CALM_TO);
                offer = (sample_backlog.size() != 0);
                if (offer && sample_backlog[0].drain_first && expected_results.size() != 0) begin
                    offer = 1'b0;
                end
                if (offer && !calm && $urandom_range(0, 99) < IDLE_PCT) begin
                    offer = 1'b0;
                end
                if (offer) begin
                    nxt = sample_backlog.pop_front();
                    s_valid   <= 1'b1;
                    s_sample  <= nxt.sample;
                    s_restart <= nxt.restart;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: checks each accepted result transaction against the
    // oldest prediction and stalls the result channel at random.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        stepdet_result_t want;
        bit              calm;

        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no prediction waiting");
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_steps_so_far !== want.steps_so_far) begin
                        $error("steps_so_far: expected %0d, actual %0d",
                               want.steps_so_far, m_steps_so_far);
                        mismatch_count++;
                    end
                    if (m_step_now !== want.step_now) begin
                        $error("step_now: expected %0d, actual %0d",
                               want.step_now, m_step_now);
                        mismatch_count++;
                    end
                    if (m_in_calibration !== want.in_calibration) begin
                        $error("in_calibration: expected %0d, actual %0d",
                               want.in_calibration, m_in_calibration);
                        mismatch_count++;
                    end
                    if (m_threshold_now !== want.threshold_now) begin
                        $error("threshold_now: expected %0d, actual %0d",
                               want.threshold_now, m_threshold_now);
                        mismatch_count++;
                    end
                end
                checked_count++;
            end
            calm = (checked_count >= CALM_FROM) && (checked_count < CALM_TO);
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("step_detector_self_calibrating verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing: reset once, build the stimulus, then wait for the last
    // result and a short tail before the verdict.
    // ------------------------------------------------------------------------
    initial begin
        clear_detector();
        build_stimulus();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (sample_backlog.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        // A result passes through the input register and the result register; the
        // tail catches any stray result.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("step_detector_self_calibrating verification clean");
        end else begin
            $display("step_detector_self_calibrating verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/stepdet_pkg.sv
sv/stepdet_core.sv
sv/step_detector_self_calibrating.sv
tb/sv/tb_step_detector_self_calibrating.sv
